// File: sv/lcgrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgrr_pkg
// Types and constants shared by the minimal standard random generator core.
// ----------------------------------------------------------------------------
package lcgrr_pkg;

   localparam int STATE_W = 31;
   localparam int VALUE_W = 32;
   localparam int SEED_W  = 32;
   localparam int MULT_W  = 15;
   localparam int PROD_W  = STATE_W + MULT_W;
   localparam int CNT_W   = 5;

   localparam logic [MULT_W-1:0]  LCG_MULT     = 15'd16807;
   localparam logic [STATE_W-1:0] LCG_MOD      = 31'h7fffffff;
   localparam logic [STATE_W-1:0] SEED_MASK    = 31'd123459876;
   localparam logic [STATE_W-1:0] SIGNED_MAX_N = 31'h3fffffff;

   // request codes on the input word
   typedef enum logic [1:0] {
      REQ_RESEED = 2'd0,
      REQ_RAW    = 2'd1,
      REQ_RANGE  = 2'd2,
      REQ_SIGNED = 2'd3
   } req_kind_type;

   // operations handed to the back end
   typedef enum logic [1:0] {
      OP_RESEED = 2'd0,
      OP_RAW    = 2'd1,
      OP_MOD    = 2'd2,
      OP_ZERO   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [STATE_W-1:0] divisor;
      logic [STATE_W-1:0] offset;
      logic [STATE_W-1:0] seed;
   } cmd_type;

endpackage

// File: sv/lcgrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgrr_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface lcgrr_req_if;
   import lcgrr_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [STATE_W-1:0] range_n;
   logic [SEED_W-1:0]  new_seed;

   modport source (output valid, output req_type, output range_n, output new_seed,
                   input ready);
   modport sink   (input valid, input req_type, input range_n, input new_seed,
                   output ready);
endinterface

interface lcgrr_rsp_if;
   import lcgrr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// File: sv/lcgrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgrr_front
// Accepts request words, decodes them into commands and queues them in a
// two-entry fifo for the back end.
// ----------------------------------------------------------------------------
module lcgrr_front (
   input  logic               clock,
   input  logic               reset,
   lcgrr_req_if.sink          req_bus,
   output logic               cmd_valid,
   output lcgrr_pkg::cmd_type cmd_out,
   input  logic               cmd_take
);
   import lcgrr_pkg::*;

   cmd_type            fifo_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               push;
   logic               pop;
   cmd_type            cmd_dec;
   logic [STATE_W-1:0] n_sat;
   logic [STATE_W-1:0] seed_low;

   // decode
   always_comb begin
      n_sat    = (req_bus.range_n > SIGNED_MAX_N) ? SIGNED_MAX_N : req_bus.range_n;
      seed_low = req_bus.new_seed[STATE_W-1:0];
      if (seed_low == SEED_MASK) begin
         seed_low = '0;
      end
      cmd_dec         = '0;
      cmd_dec.seed    = seed_low ^ SEED_MASK;
      unique case (req_kind_type'(req_bus.req_type))
         REQ_RESEED: begin
            cmd_dec.op = OP_RESEED;
         end
         REQ_RAW: begin
            cmd_dec.op = OP_RAW;
         end
         REQ_RANGE: begin
            cmd_dec.op      = (req_bus.range_n == '0) ? OP_ZERO : OP_MOD;
            cmd_dec.divisor = req_bus.range_n;
         end
         REQ_SIGNED: begin
            cmd_dec.op      = (n_sat == '0) ? OP_ZERO : OP_MOD;
            cmd_dec.divisor = {n_sat[STATE_W-2:0], 1'b0};
            cmd_dec.offset  = n_sat;
         end
         default: begin
            cmd_dec.op = OP_ZERO;
         end
      endcase
   end

   // queue control
   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = cmd_take && cmd_valid;
   assign cmd_valid     = (count_ff != 2'd0);
   assign cmd_out       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("command queue count out of range");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_bus.ready)
      else $error("request accepted while queue full");

endmodule

// File: sv/lcgrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgrr_back
// Holds the generator state, steps it by multiply and fold mod 2^31-1,
// reduces the draw by a one-bit-per-cycle restoring divider and drives the
// response register.
// ----------------------------------------------------------------------------
module lcgrr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  lcgrr_pkg::cmd_type cmd_in,
   output logic               cmd_take,
   lcgrr_rsp_if.source        rsp_bus
);
   import lcgrr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RED,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                 state_ff;
   op_type                    op_ff;
   logic [STATE_W-1:0]        gen_state_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [STATE_W-1:0]        div_ff;
   logic [STATE_W-1:0]        offset_ff;
   logic [STATE_W-1:0]        rem_ff;
   logic [STATE_W-1:0]        quo_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [VALUE_W-1:0] result_ff;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic [PROD_W-1:0]         prod_in;
   logic [STATE_W:0]          fold_sum;
   logic [STATE_W-1:0]        red_val;
   logic [STATE_W:0]          trial;
   logic [STATE_W-1:0]        rem_in;
   logic [VALUE_W-1:0]        diff;
   logic                      out_free;

   always_comb begin
      prod_in  = PROD_W'(gen_state_ff) * PROD_W'(LCG_MULT);
      fold_sum = {1'b0, prod_ff[STATE_W-1:0]} + (STATE_W+1)'(prod_ff[PROD_W-1:STATE_W]);
      red_val  = (fold_sum >= {1'b0, LCG_MOD}) ?
                 STATE_W'(fold_sum - {1'b0, LCG_MOD}) : fold_sum[STATE_W-1:0];
      trial    = {rem_ff, quo_ff[STATE_W-1]};
      rem_in   = (trial >= {1'b0, div_ff}) ?
                 STATE_W'(trial - {1'b0, div_ff}) : trial[STATE_W-1:0];
      diff     = {1'b0, rem_in} - {1'b0, offset_ff};
   end

   assign cmd_take      = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_state_ff <= SEED_MASK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  op_ff     <= cmd_in.op;
                  div_ff    <= cmd_in.divisor;
                  offset_ff <= cmd_in.offset;
                  prod_ff   <= prod_in;
                  unique case (cmd_in.op)
                     OP_RESEED: begin
                        result_ff    <= VALUE_W'(gen_state_ff);
                        gen_state_ff <= cmd_in.seed;
                        state_ff     <= ST_OUT;
                     end
                     OP_ZERO: begin
                        result_ff <= '0;
                        state_ff  <= ST_OUT;
                     end
                     default: begin
                        state_ff <= ST_RED;
                     end
                  endcase
               end
            end
            ST_RED: begin
               gen_state_ff <= red_val;
               if (op_ff == OP_RAW) begin
                  result_ff <= VALUE_W'(red_val);
                  state_ff  <= ST_OUT;
               end else begin
                  rem_ff   <= '0;
                  quo_ff   <= red_val;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[STATE_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(STATE_W - 1)) begin
                  result_ff <= diff;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  value_ff <= result_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_bus.valid)
      else $error("finished word not presented");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(rsp_bus.value)))
      else $error("response word changed while stalled");

endmodule

// File: sv/lcg_random_range_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_range_generator_core
// Minimal standard multiplicative generator (x * 16807 mod 2^31-1) with
// reseed, raw draw, unsigned range draw and signed range draw requests.
// ----------------------------------------------------------------------------
// One request word gives one response word. A reseed or a draw with a zero
// range goes from the queue straight to the output state, a raw draw passes
// the generator step first, and a range draw the divider as well: the step
// takes a multiply and a fold, and the remainder comes from a restoring
// divider that retires one bit per cycle. Work is done one request at a time; a
// two-entry command queue in front keeps accepting, until it holds two commands,
// while the back end is busy or a response waits to be taken.
module lcg_random_range_generator_core (
   input  logic        clock,
   input  logic        reset,
   lcgrr_req_if.sink   req_bus,
   lcgrr_rsp_if.source rsp_bus
);
   import lcgrr_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   lcgrr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_out   (cmd),
      .cmd_take  (cmd_take)
   );

   lcgrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_in    (cmd),
      .cmd_take  (cmd_take),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: test/lcg_random_range_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_range_generator_core_tb
// Drives reseed, raw, range and signed range request words into the core and
// checks every response word against a behavioral copy of the generator or a
// typed-in value. A short table of directed words hits the bound and seed
// corners, then random words follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
module lcg_random_range_generator_core_tb;
   import lcgrr_pkg::*;

   localparam int RANDOM_WORDS = 1700;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      req_kind_type        kind;
      logic [STATE_W-1:0]  bound;
      logic [SEED_W-1:0]   seed;
      bit                  known;
      logic signed [VALUE_W-1:0] value;
   } stim_row_type;

   logic clock;
   logic reset;

   lcgrr_req_if req_bus ();
   lcgrr_rsp_if rsp_bus ();

   lcg_random_range_generator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   logic [STATE_W-1:0]        lcg_state;
   logic signed [VALUE_W-1:0] pending_values [$];
   bit   steady_flow;
   int   fail_count;
   int   checked_words;
   int   stall_cycles;
   int   kind_count [4];
   int   zero_bound_count;

   // bound and seed corners, value typed in where it is obvious
   stim_row_type directed_rows [0:24] = '{
      '{REQ_RANGE,  31'd0,          32'hffff_ffff,              1'b1, 32'sd0},
      '{REQ_SIGNED, 31'd0,          32'hffff_ffff,              1'b1, 32'sd0},
      '{REQ_RESEED, 31'h7fff_ffff,  {1'b1, SEED_MASK ^ LCG_MOD}, 1'b1, 32'sd123459876},
      '{REQ_RESEED, 31'd0,          {1'b0, SEED_MASK ^ LCG_MOD}, 1'b1, 32'sh7fff_ffff},
      '{REQ_RAW,    31'h7fff_ffff,  32'h0000_0000,              1'b1, 32'sd0},
      '{REQ_RAW,    31'd0,          32'hffff_ffff,              1'b1, 32'sd0},
      '{REQ_RANGE,  31'h7fff_ffff,  32'h0000_0000,              1'b1, 32'sd0},
      '{REQ_SIGNED, 31'h7fff_ffff,  32'h0000_0000,              1'b1, -32'sd1073741823},
      '{REQ_SIGNED, 31'd1,          32'h0000_0000,              1'b1, -32'sd1},
      '{REQ_SIGNED, 31'd5,          32'h0000_0000,              1'b1, -32'sd5},
      '{REQ_RESEED, 31'd0,          {1'b0, SEED_MASK},          1'b1, 32'sd0},
      '{REQ_RESEED, 31'd0,          {1'b1, SEED_MASK},          1'b1, 32'sd123459876},
      '{REQ_RESEED, 31'd0,          32'h0000_0000,              1'b1, 32'sd123459876},
      '{REQ_RAW,    31'd0,          32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_RANGE,  31'd1,          32'h0000_0000,              1'b1, 32'sd0},
      '{REQ_RANGE,  31'h7fff_ffff,  32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_SIGNED, SIGNED_MAX_N,   32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_SIGNED, 31'h4000_0000,  32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_RANGE,  31'd2,          32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_RESEED, 31'd0,          32'hffff_ffff,              1'b0, 32'sd0},
      '{REQ_RAW,    31'd0,          32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_RANGE,  31'd0,          32'h1234_5678,              1'b1, 32'sd0},
      '{REQ_SIGNED, 31'd1,          32'h0000_0000,              1'b0, 32'sd0},
      '{REQ_RESEED, 31'h2aaa_aaaa,  32'h5555_5555,              1'b0, 32'sd0},
      '{REQ_RANGE,  31'h5555_5555,  32'haaaa_aaaa,              1'b0, 32'sd0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [STATE_W-1:0] next_lcg_state(input logic [STATE_W-1:0] s);
      logic [63:0] product;
      product = 64'(s) * 64'(LCG_MULT);
      return STATE_W'(product % 64'(LCG_MOD));
   endfunction

   // value of one response word, stepping or reseeding the generator copy as the request does
   function automatic logic signed [VALUE_W-1:0] draw_value(input req_kind_type kind,
                                                            input logic [STATE_W-1:0] bound,
                                                            input logic [SEED_W-1:0] seed);
      logic [STATE_W-1:0] s;
      logic [STATE_W-1:0] n;
      logic [VALUE_W-1:0] span;
      logic [VALUE_W-1:0] result;
      result = '0;
      case (kind)
         REQ_RESEED: begin
            result = {1'b0, lcg_state};
            s = seed[STATE_W-1:0];
            if (s == SEED_MASK) s = '0;
            lcg_state = s ^ SEED_MASK;
         end
         REQ_RAW: begin
            lcg_state = next_lcg_state(lcg_state);
            result = {1'b0, lcg_state};
         end
         REQ_RANGE: begin
            if (bound != '0) begin
               lcg_state = next_lcg_state(lcg_state);
               result = {1'b0, lcg_state} % {1'b0, bound};
            end
         end
         default: begin
            n = (bound > SIGNED_MAX_N) ? SIGNED_MAX_N : bound;
            if (n != '0) begin
               lcg_state = next_lcg_state(lcg_state);
               span = {n, 1'b0};
               result = ({1'b0, lcg_state} % span) - {1'b0, n};
            end
         end
      endcase
      return result;
   endfunction

   // present one word, idling at random first; returns at the accepting edge
   task automatic send_word(input req_kind_type kind, input logic [STATE_W-1:0] bound,
                            input logic [SEED_W-1:0] seed, input bit known,
                            input logic signed [VALUE_W-1:0] known_value);
      logic signed [VALUE_W-1:0] predicted;
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 37) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.range_n  <= bound;
      req_bus.new_seed <= seed;
      do @(posedge clock); while (!req_bus.ready);
      predicted = draw_value(kind, bound, seed);
      pending_values.push_back(known ? known_value : predicted);
      kind_count[kind]++;
      if (kind inside {REQ_RANGE, REQ_SIGNED} && bound == '0) zero_bound_count++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_values.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 37);
   end

   // response check and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_words++;
            if (pending_values.size() == 0) begin
               $display("%0t: response word with nothing expected, got %0d (0x%08h)",
                        $time, rsp_bus.value, rsp_bus.value);
               fail_count++;
            end else if (rsp_bus.value !== pending_values[0]) begin
               $display("%0t: value mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                        $time, pending_values[0], pending_values[0],
                        rsp_bus.value, rsp_bus.value);
               fail_count++;
               void'(pending_values.pop_front());
            end else begin
               void'(pending_values.pop_front());
            end
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int                 pick;
      req_kind_type       kind;
      logic [STATE_W-1:0] bound;
      logic [SEED_W-1:0]  seed;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_RESEED;
      req_bus.range_n  = '0;
      req_bus.new_seed = '0;
      rsp_bus.ready    = 1'b0;
      steady_flow      = 1'b0;
      fail_count       = 0;
      checked_words    = 0;
      stall_cycles     = 0;
      zero_bound_count = 0;
      kind_count       = '{0, 0, 0, 0};
      lcg_state        = SEED_MASK;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_word(directed_rows[r].kind, directed_rows[r].bound, directed_rows[r].seed,
                   directed_rows[r].known, directed_rows[r].value);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         steady_flow = (i >= 700 && i < 1000);
         if (i % 450 == 449) wait_for_drain();

         pick = $urandom_range(99);
         if (pick < 10)      kind = REQ_RESEED;
         else if (pick < 35) kind = REQ_RAW;
         else if (pick < 68) kind = REQ_RANGE;
         else                kind = REQ_SIGNED;

         pick = $urandom_range(99);
         if (pick < 8)       bound = '0;
         else if (pick < 45) bound = STATE_W'($urandom_range(1, 64));
         else if (pick < 58) bound = STATE_W'(1) << $urandom_range(0, STATE_W - 1);
         else if (pick < 68) bound = LCG_MOD - STATE_W'($urandom_range(0, 3));
         else if (pick < 78) bound = SIGNED_MAX_N + STATE_W'($urandom_range(0, 4))
                                     - STATE_W'(2);
         else                bound = STATE_W'($urandom());

         pick = $urandom_range(99);
         if (pick < 5)       seed = {1'($urandom()), SEED_MASK};
         else if (pick < 10) seed = {1'($urandom()), SEED_MASK ^ LCG_MOD};
         else                seed = $urandom();

         send_word(kind, bound, seed, 1'b0, '0);
      end

      steady_flow = 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words: %0d reseed, %0d raw, %0d range, %0d signed",
               kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
               kind_count[REQ_RESEED], kind_count[REQ_RAW], kind_count[REQ_RANGE],
               kind_count[REQ_SIGNED]);
      $display("%0d draws with a zero bound, %0d response words checked, %0d mismatches",
               zero_bound_count, checked_words, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
